@@ rtl/core/dgsp_pkg.sv @@
// ----------------------------------------------------------------------------
// dgsp_pkg
// Shared types and constants for the dense graph shortest path engine.
// ----------------------------------------------------------------------------
package dgsp_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int VIDX_W       = $clog2(MAX_VERTICES);
    localparam int COUNT_W      = $clog2(MAX_VERTICES + 1);
    localparam int WEIGHT_W     = 16;
    localparam int DIST_W       = 22;
    localparam int WADDR_W      = 2 * VIDX_W;
    localparam int WDEPTH       = MAX_VERTICES * MAX_VERTICES;

    localparam logic [DIST_W-1:0]  DIST_INF        = {DIST_W{1'b1}};
    localparam logic [DIST_W-1:0]  DIST_MAX_FINITE = DIST_INF - 1'b1;
    localparam logic [COUNT_W-1:0] VCOUNT_RESET    = COUNT_W'(MAX_VERTICES);

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_RUN   = 1'b1
    } dgsp_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED,
        ST_SELECT,
        ST_RELAX,
        ST_OUTPUT
    } dgsp_state_t;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_SEED,
        MODE_RELAX,
        MODE_OUTPUT
    } dgsp_mode_t;

    typedef struct packed {
        logic       load_weight;
        logic       run_init;
        logic       begin_pass;
        logic       take_pick;
        dgsp_mode_t mode;
    } dgsp_cmd_t;

    typedef struct packed {
        logic pass_done;
        logic found;
    } dgsp_status_t;

endpackage

@@ rtl/core/dense_graph_shortest_paths_top.sv @@
// ----------------------------------------------------------------------------
// dense_graph_shortest_paths_top
// A weight write completes in the cycle it is accepted; start may be raised again on the next one.
// A run over n vertices that reaches k vertices besides the source keeps busy
// high through a seed pass, one relax pass per reached vertex and an output
// pass: the seed and relax passes each read one weight-memory row, drain the
// read pipeline and go to the select step. Results stream one per cycle at the end
// and the receiver cannot stall them. Reset clears the vertex count to 64 and
// the visited flags; weight and distance memories are undefined until written.
// ----------------------------------------------------------------------------
module dense_graph_shortest_paths_top
    import dgsp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                opcode,
    input  logic [VIDX_W-1:0]   row_vertex,
    input  logic [VIDX_W-1:0]   col_vertex,
    input  logic [WEIGHT_W-1:0] edge_weight,
    input  logic [VIDX_W-1:0]   source_vertex,
    input  logic                cfg_we,
    input  logic [COUNT_W-1:0]  cfg_wdata,
    output logic                result_valid,
    output logic [VIDX_W-1:0]   vertex_index,
    output logic [DIST_W-1:0]   distance,
    output logic                last
);

    dgsp_cmd_t    cmd;
    dgsp_status_t status;

    dgsp_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .opcode (opcode),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    dgsp_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .row_vertex    (row_vertex),
        .col_vertex    (col_vertex),
        .edge_weight   (edge_weight),
        .source_vertex (source_vertex),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .result_valid  (result_valid),
        .vertex_index  (vertex_index),
        .distance      (distance),
        .last          (last)
    );

endmodule

@@ rtl/core/dgsp_ram.sv @@
// ----------------------------------------------------------------------------
// dgsp_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module dgsp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/dgsp_ctrl.sv @@
// ----------------------------------------------------------------------------
// dgsp_ctrl
// Sequencer for weight loads and the seed, select, relax and output passes.
// ----------------------------------------------------------------------------
module dgsp_ctrl
    import dgsp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic         opcode,
    input  dgsp_status_t status,
    output dgsp_cmd_t    cmd,
    output logic         busy
);

    dgsp_state_t state_reg;
    dgsp_state_t state_next;
    logic        accept;

    assign accept = start && (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (opcode == OP_RUN))
                begin
                    state_next = ST_SEED;
                end
            end
            ST_SEED, ST_RELAX:
            begin
                if (status.pass_done)
                begin
                    state_next = ST_SELECT;
                end
            end
            ST_SELECT:
            begin
                state_next = status.found ? ST_RELAX : ST_OUTPUT;
            end
            ST_OUTPUT:
            begin
                if (status.pass_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                busy            = 1'b0;
                cmd.mode        = MODE_IDLE;
                cmd.load_weight = accept && (opcode == OP_WRITE);
                cmd.run_init    = accept && (opcode == OP_RUN);
                cmd.begin_pass  = accept && (opcode == OP_RUN);
            end
            ST_SEED:
            begin
                cmd.mode = MODE_SEED;
            end
            ST_SELECT:
            begin
                // The nearest vertex found by the last pass, if any, is marked here.
                cmd.mode       = MODE_IDLE;
                cmd.begin_pass = 1'b1;
                cmd.take_pick  = status.found;
            end
            ST_RELAX:
            begin
                cmd.mode = MODE_RELAX;
            end
            ST_OUTPUT:
            begin
                cmd.mode = MODE_OUTPUT;
            end
            default:
            begin
                cmd.mode = MODE_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/core/dgsp_datapath.sv @@
// ----------------------------------------------------------------------------
// dgsp_datapath
// Weight and distance memories, visited flags, relaxation and minimum tracker.
// ----------------------------------------------------------------------------
module dgsp_datapath
    import dgsp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  dgsp_cmd_t           cmd,
    output dgsp_status_t        status,
    input  logic [VIDX_W-1:0]   row_vertex,
    input  logic [VIDX_W-1:0]   col_vertex,
    input  logic [WEIGHT_W-1:0] edge_weight,
    input  logic [VIDX_W-1:0]   source_vertex,
    input  logic                cfg_we,
    input  logic [COUNT_W-1:0]  cfg_wdata,
    output logic                result_valid,
    output logic [VIDX_W-1:0]   vertex_index,
    output logic [DIST_W-1:0]   distance,
    output logic                last
);

    // Control state.
    logic [COUNT_W-1:0]      vertex_count_reg;
    logic [MAX_VERTICES-1:0] visited_reg;
    logic [MAX_VERTICES-1:0] visited_next;
    logic [COUNT_W-1:0]      idx_reg;
    logic [COUNT_W-1:0]      idx_next;
    logic                    s1_valid_reg;

    // Payload state.
    logic [COUNT_W-1:0]      n_reg;
    logic [COUNT_W-1:0]      n_next;
    logic [VIDX_W-1:0]       src_reg;
    logic                    src_ok_reg;
    logic [VIDX_W-1:0]       pick_reg;
    logic [DIST_W-1:0]       near_reg;
    logic [DIST_W-1:0]       min_reg;
    logic [DIST_W-1:0]       min_next;
    logic [VIDX_W-1:0]       min_idx_reg;
    logic [VIDX_W-1:0]       min_idx_next;
    logic [VIDX_W-1:0]       s1_idx_reg;

    logic                    issue;
    logic                    active;
    logic [WADDR_W-1:0]      w_waddr;
    logic [WADDR_W-1:0]      w_raddr;
    logic [WEIGHT_W-1:0]     w_q;
    logic                    d_we;
    logic [DIST_W-1:0]       d_wdata;
    logic [DIST_W-1:0]       d_q;
    logic                    unvisited;
    logic [DIST_W:0]         sum_wide;
    logic [DIST_W-1:0]       sum_sat;
    logic [DIST_W-1:0]       seed_dist;
    logic                    relax_upd;
    logic [DIST_W-1:0]       cand;

    assign active = (cmd.mode == MODE_SEED) || (cmd.mode == MODE_RELAX)
                 || (cmd.mode == MODE_OUTPUT);
    assign issue  = active && (idx_reg < n_reg);

    // Vertex count is clamped to the range the engine supports.
    always_comb
    begin
        if (vertex_count_reg == '0)
        begin
            n_next = COUNT_W'(1);
        end
        else if (vertex_count_reg > COUNT_W'(MAX_VERTICES))
        begin
            n_next = COUNT_W'(MAX_VERTICES);
        end
        else
        begin
            n_next = vertex_count_reg;
        end
    end

    assign w_waddr = {row_vertex, col_vertex};
    assign w_raddr = {(cmd.mode == MODE_SEED) ? src_reg : pick_reg,
                      idx_reg[VIDX_W-1:0]};

    dgsp_ram #(
        .WIDTH (WEIGHT_W),
        .DEPTH (WDEPTH)
    ) u_weight_ram (
        .clk   (clk),
        .we    (cmd.load_weight),
        .waddr (w_waddr),
        .wdata (edge_weight),
        .raddr (w_raddr),
        .rdata (w_q)
    );

    dgsp_ram #(
        .WIDTH (DIST_W),
        .DEPTH (MAX_VERTICES)
    ) u_dist_ram (
        .clk   (clk),
        .we    (d_we),
        .waddr (s1_idx_reg),
        .wdata (d_wdata),
        .raddr (idx_reg[VIDX_W-1:0]),
        .rdata (d_q)
    );

    assign unvisited = !visited_reg[s1_idx_reg];
    assign sum_wide  = {1'b0, near_reg} + (DIST_W + 1)'(w_q);
    assign sum_sat   = (sum_wide > {1'b0, DIST_MAX_FINITE}) ? DIST_MAX_FINITE
                                                              : sum_wide[DIST_W-1:0];
    assign relax_upd = unvisited && (w_q != '0) && (sum_sat < d_q);

    always_comb
    begin
        if (!src_ok_reg)
        begin
            seed_dist = DIST_INF;
        end
        else if (s1_idx_reg == src_reg)
        begin
            seed_dist = '0;
        end
        else if (w_q == '0)
        begin
            seed_dist = DIST_INF;
        end
        else
        begin
            seed_dist = DIST_W'(w_q);
        end
    end

    always_comb
    begin
        d_we    = 1'b0;
        d_wdata = seed_dist;
        cand    = d_q;
        case (cmd.mode)
            MODE_SEED:
            begin
                d_we    = s1_valid_reg;
                d_wdata = seed_dist;
                cand    = seed_dist;
            end
            MODE_RELAX:
            begin
                d_we    = s1_valid_reg && relax_upd;
                d_wdata = sum_sat;
                cand    = relax_upd ? sum_sat : d_q;
            end
            default:
            begin
                d_we    = 1'b0;
                d_wdata = seed_dist;
                cand    = d_q;
            end
        endcase
    end

    // The nearest unvisited vertex for the next step is tracked while the
    // current pass writes its distances; a strict compare keeps the lowest index.
    always_comb
    begin
        min_next     = min_reg;
        min_idx_next = min_idx_reg;
        if (cmd.begin_pass)
        begin
            min_next = DIST_INF;
        end
        else if (s1_valid_reg && unvisited && (cand < min_reg)
                 && ((cmd.mode == MODE_SEED) || (cmd.mode == MODE_RELAX)))
        begin
            min_next     = cand;
            min_idx_next = s1_idx_reg;
        end
    end

    always_comb
    begin
        visited_next = visited_reg;
        if (cmd.run_init)
        begin
            visited_next = '0;
            if ({1'b0, source_vertex} < n_next)
            begin
                visited_next[source_vertex] = 1'b1;
            end
        end
        else if (cmd.take_pick)
        begin
            visited_next[min_idx_reg] = 1'b1;
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.begin_pass)
        begin
            idx_next = '0;
        end
        else if (issue)
        begin
            idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg <= VCOUNT_RESET;
            visited_reg      <= '0;
            idx_reg          <= '0;
            s1_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                vertex_count_reg <= cfg_wdata;
            end
            visited_reg  <= visited_next;
            idx_reg      <= idx_next;
            s1_valid_reg <= issue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.run_init)
        begin
            n_reg      <= n_next;
            src_reg    <= source_vertex;
            src_ok_reg <= ({1'b0, source_vertex} < n_next);
        end
        if (cmd.take_pick)
        begin
            pick_reg <= min_idx_reg;
            near_reg <= min_reg;
        end
        min_reg     <= min_next;
        min_idx_reg <= min_idx_next;
        s1_idx_reg  <= idx_reg[VIDX_W-1:0];
    end

    assign status.pass_done = (idx_reg == n_reg) && !s1_valid_reg;
    assign status.found     = (min_reg != DIST_INF);

    assign result_valid = s1_valid_reg && (cmd.mode == MODE_OUTPUT);
    assign vertex_index = s1_idx_reg;
    assign distance     = d_q;
    assign last         = ({1'b0, s1_idx_reg} == COUNT_W'(n_reg - 1'b1));

endmodule
